### hw/rtl/address_hit_counter_table_core_defines.svh
// ----------------------------------------------------------------------------
// Address hit counter table: assertion macros
// Shared concurrent assertion forms, clocked on clk with rst as the reset.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_HIT_COUNTER_TABLE_CORE_DEFINES_SVH
`define ADDRESS_HIT_COUNTER_TABLE_CORE_DEFINES_SVH

// Checked only outside reset.
`define AHCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define AHCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/ahct_pkg.sv
// ----------------------------------------------------------------------------
// Address hit counter table package
// Table sizing, control and status types shared by the controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ahct_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = 32;
  localparam int COUNT_W     = 32;
  localparam int RANK_W      = 4;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 40;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  function automatic logic [RANK_W-1:0] to_rank(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[RANK_W-1:0];
  endfunction

endpackage

### hw/rtl/ahct_ctrl.sv
// ----------------------------------------------------------------------------
// Address hit counter table controller
// Sequences each item through lookup capture and table commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ahct_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  ahct_pkg::stat_t stat,
  output ahct_pkg::ctrl_t ctrl
);
  import ahct_pkg::*;

  localparam logic S_ACC = 1'b0;
  localparam logic S_UPD = 1'b1;

  logic state;
  logic state_next;

  assign s_tready     = (state == S_ACC);
  assign ctrl.capture = s_tvalid && s_tready;
  assign ctrl.commit  = (state == S_UPD) && !stat.out_busy;

  always_comb begin
    state_next = state;
    unique case (state)
      S_ACC: begin
        if (ctrl.capture) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        if (ctrl.commit) begin
          state_next = S_ACC;
        end
      end
      default: state_next = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/ahct_datapath.sv
// ----------------------------------------------------------------------------
// Address hit counter table datapath
// Register cells with parallel address compare, ordered segment shift and
// the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "address_hit_counter_table_core_defines.svh"

module ahct_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  ahct_pkg::ctrl_t                  ctrl,
  output ahct_pkg::stat_t                  stat,
  input  logic [ahct_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [0:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ahct_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [1:0]                       m_tuser
);
  import ahct_pkg::*;

  logic [ADDR_W-1:0]  cell_addr  [TABLE_DEPTH];
  logic [COUNT_W-1:0] cell_count [TABLE_DEPTH];
  logic [OCC_W-1:0]   occ;

  logic               cmd_q;
  logic [ADDR_W-1:0]  addr_q;
  logic               hit_q;
  logic [IDX_W-1:0]   pos_q;
  logic [COUNT_W-1:0] cnt_q;

  logic               look_hit;
  logic [IDX_W-1:0]   look_pos;
  logic [COUNT_W-1:0] look_cnt;

  logic               full;
  logic [COUNT_W-1:0] cnt_inc;
  logic [IDX_W-1:0]   dest;
  logic               dest_found;
  logic               do_move;
  logic               do_append;

  logic [COUNT_W-1:0] res_count;
  logic               res_found;
  logic [RANK_W-1:0]  res_rank;
  logic               res_dropped;

  assign stat.out_busy = m_tvalid && !m_tready;
  assign full          = (occ == OCC_W'(TABLE_DEPTH));

  always_comb begin
    look_hit = 1'b0;
    look_pos = '0;
    look_cnt = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!look_hit && (OCC_W'(i) < occ) && (cell_addr[i] == s_tdata[ADDR_W-1:0])) begin
        look_hit = 1'b1;
        look_pos = IDX_W'(i);
        look_cnt = cell_count[i];
      end
    end
  end

  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    dest       = pos_q;
    dest_found = 1'b0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (!dest_found && (IDX_W'(k) < pos_q) && (cell_count[k] < cnt_inc)) begin
        dest       = IDX_W'(k);
        dest_found = 1'b1;
      end
    end
  end

  assign do_move   = (cmd_q == CMD_RECORD) && hit_q;
  assign do_append = (cmd_q == CMD_RECORD) && !hit_q && !full;

  always_comb begin
    res_count   = '0;
    res_found   = 1'b0;
    res_rank    = '0;
    res_dropped = 1'b0;
    if (hit_q) begin
      res_found = 1'b1;
      if (cmd_q == CMD_QUERY) begin
        res_count = cnt_q;
        res_rank  = to_rank(pos_q);
      end else begin
        res_count = cnt_inc;
        res_rank  = to_rank(dest);
      end
    end else if (do_append) begin
      res_count = COUNT_W'(1);
      res_found = 1'b1;
      res_rank  = to_rank(occ[IDX_W-1:0]);
    end else if (cmd_q == CMD_RECORD) begin
      res_dropped = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q  <= s_tuser[0];
      addr_q <= s_tdata[ADDR_W-1:0];
      hit_q  <= look_hit;
      pos_q  <= look_pos;
      cnt_q  <= look_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        if (do_move && (IDX_W'(k) == dest)) begin
          cell_addr[k]  <= addr_q;
          cell_count[k] <= cnt_inc;
        end else if (do_move && (IDX_W'(k) > dest) && (IDX_W'(k) <= pos_q) && (k > 0)) begin
          cell_addr[k]  <= cell_addr[(k > 0) ? k - 1 : 0];
          cell_count[k] <= cell_count[(k > 0) ? k - 1 : 0];
        end else if (do_append && (OCC_W'(k) == occ)) begin
          cell_addr[k]  <= addr_q;
          cell_count[k] <= COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (ctrl.commit && do_append) begin
      occ <= occ + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      m_tdata <= {{(OUT_DATA_W - COUNT_W - RANK_W){1'b0}}, res_rank, res_count};
      m_tuser <= {res_dropped, res_found};
    end
  end

  `AHCT_ASSERT(a_occ_bound, occ <= OCC_W'(TABLE_DEPTH), "occupancy beyond table depth")
  `AHCT_ASSERT(a_commit_free, ctrl.commit |-> !(m_tvalid && !m_tready), "commit over pending result")
  `AHCT_ASSERT(a_append_grows, ctrl.commit && do_append |=> occ == $past(occ) + 1'b1, "append lost")
  `AHCT_ASSERT(a_drop_full, m_tvalid && m_tuser[1] |-> full, "drop with free space")

endmodule

### hw/rtl/address_hit_counter_table_core.sv
// ----------------------------------------------------------------------------
// Address hit counter table core
// Counts hits per IPv4 address in a table kept in descending count order.
// ----------------------------------------------------------------------------
// Each transfer is taken one at a time: in the accept cycle the address is
// compared against every occupied table entry at once and the match is
// registered, and in the commit state that follows the count is raised and
// the entry moves up through a shift of the register cells between its new
// and old places. The commit waits while an earlier result on the master side
// has not yet been taken. The table is empty after reset, with no clearing pass.
`timescale 1ns / 1ps

module address_hit_counter_table_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ahct_pkg::IN_DATA_W-1:0]   s_tdata,   // address
  input  logic [0:0]                       s_tuser,   // cmd
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ahct_pkg::OUT_DATA_W-1:0]  m_tdata,   // hit_count, rank, zero fill
  output logic [1:0]                       m_tuser    // found, dropped
);
  import ahct_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  ahct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  ahct_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
